// ===== hdl/baro_pkg.sv =====
package baro_pkg;

    localparam int unsigned OVERSAMPLING = 0;
    localparam logic [1:0]  OSS          = OVERSAMPLING[1:0];
    localparam int unsigned DIV_STEPS    = 32;

    localparam logic [31:0] B6_OFFSET    = 32'd4000;
    localparam logic [31:0] POLY_SQ      = 32'd3038;
    localparam logic [31:0] POLY_LIN     = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] POLY_BIAS    = 32'd3791;
    localparam logic [31:0] B7_SCALE     = 32'd50000 >> OSS;
    localparam logic [31:0] B4_BIAS      = 32'd32768;
    localparam logic [31:0] TEMP_ROUND   = 32'd8;

    localparam logic OP_TEMP  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    typedef enum logic [3:0] {
        REG_A1   = 4'd0,
        REG_A2   = 4'd1,
        REG_A3   = 4'd2,
        REG_A4   = 4'd3,
        REG_A5   = 4'd4,
        REG_A6   = 4'd5,
        REG_QUAD = 4'd6,
        REG_TEMP = 4'd7
    } t_reg_idx;

    // side information carried with each word
    typedef struct packed {
        logic        op;
        logic        bad;
        logic        flag;   // quotient negate, or quotient double
        logic [18:0] up;
        logic [31:0] val;
    } t_ctx;

    typedef struct packed {
        logic        valid;
        logic [31:0] rem;
        logic [31:0] num;
        logic [31:0] den;
        t_ctx        ctx;
    } t_div;

endpackage

// ===== hdl/barometer_compensation.sv =====
// The result word passes through 75 register stages, two rows of 32 divider cells among
// them, from the register that accepts its input word to the output register.
// One word per cycle while the output is not stalled; each divider is a row of 32 cells,
// one quotient bit per cell, and all stages advance together.
// The whole pipeline holds while the output word waits on i_m_tready.
// Reset (synchronous, active low) clears all valid bits and the
// calibration registers to zero.
module barometer_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [15:0] raw_temp, [34:16] raw_pressure
    input  logic        i_s_tuser,   // op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] value
    output logic        o_m_tuser    // status
);

    logic en;
    assign en         = ~(o_m_tvalid & ~i_m_tready);
    assign o_s_tready = en;

    // calibration
    logic [15:0] r_a1, r_a2, r_a3, r_a4, r_a5, r_a6;
    logic [31:0] r_quad, r_temp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1 <= '0; r_a2 <= '0; r_a3 <= '0; r_a4 <= '0;
            r_a5 <= '0; r_a6 <= '0; r_quad <= '0; r_temp <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                baro_pkg::REG_A1:   r_a1   <= i_cfg_data[15:0];
                baro_pkg::REG_A2:   r_a2   <= i_cfg_data[15:0];
                baro_pkg::REG_A3:   r_a3   <= i_cfg_data[15:0];
                baro_pkg::REG_A4:   r_a4   <= i_cfg_data[15:0];
                baro_pkg::REG_A5:   r_a5   <= i_cfg_data[15:0];
                baro_pkg::REG_A6:   r_a6   <= i_cfg_data[15:0];
                baro_pkg::REG_QUAD: r_quad <= i_cfg_data;
                baro_pkg::REG_TEMP: r_temp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [31:0] a1, a2, a3, a4, a5, a6, qs, qo, tn, td;
    assign a1 = {{16{r_a1[15]}}, r_a1};
    assign a2 = {{16{r_a2[15]}}, r_a2};
    assign a3 = {{16{r_a3[15]}}, r_a3};
    assign a4 = {16'd0, r_a4};
    assign a5 = {16'd0, r_a5};
    assign a6 = {16'd0, r_a6};
    assign qs = {{16{r_quad[31]}}, r_quad[31:16]};
    assign qo = {{16{r_quad[15]}}, r_quad[15:0]};
    assign tn = {{16{r_temp[31]}}, r_temp[31:16]};
    assign td = {{16{r_temp[15]}}, r_temp[15:0]};

    // valid bits of the arithmetic stages
    logic r1_v, r2_v, r4_v, r5_v, r6_v, r7_v, r8_v, r10_v, r11_v, r12_v;
    baro_pkg::t_ctx r1_c, r2_c, r4_c, r5_c, r6_c, r7_c, r8_c, r10_c, r11_c, r12_c;
    logic [15:0] r1_ut;
    logic [31:0] r2_x1;
    logic [31:0] r4_b6;
    logic [31:0] r5_b6sq, r5_a2b6, r5_a3b6;
    logic [31:0] r6_qosq, r6_qssq, r6_x2, r6_x1b;
    logic [31:0] r7_b3, r7_x3b;
    logic [31:0] r8_b4, r8_b7;
    logic [31:0] r10_p;
    logic [31:0] r11_p, r11_sq, r11_lin;
    logic [31:0] r12_p, r12_x1, r12_x2;
    logic        r_out_v;
    logic [31:0] r_out_val;
    logic        r_out_st;
    baro_pkg::t_div d1_in, d1_out, d2_in, d2_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r4_v <= 1'b0; r5_v <= 1'b0; r6_v <= 1'b0;
            r7_v <= 1'b0; r8_v <= 1'b0; r10_v <= 1'b0; r11_v <= 1'b0; r12_v <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_s_tvalid; r2_v <= r1_v;
            r4_v <= d1_out.valid; r5_v <= r4_v; r6_v <= r5_v; r7_v <= r6_v;
            r8_v <= r7_v; r10_v <= d2_out.valid; r11_v <= r10_v; r12_v <= r11_v;
            r_out_v <= r12_v;
        end
    end

    // temperature front end and first divider
    logic [31:0]    n_x1;
    logic [31:0]    den, tnum;

    assign n_x1 = $unsigned($signed(({16'd0, r1_ut} - a6) * a5) >>> 15);

    always_comb begin
        den  = r2_x1 + td;
        tnum = tn << 11;
        d1_in.valid    = r2_v;
        d1_in.rem      = '0;
        d1_in.num      = tnum[31] ? 32'd0 - tnum : tnum;
        d1_in.den      = den[31] ? 32'd0 - den : den;
        d1_in.ctx      = r2_c;
        d1_in.ctx.val  = r2_x1;
        d1_in.ctx.flag = tnum[31] ^ den[31];
        d1_in.ctx.bad  = (den == 32'd0);
    end

    baro_div_row u_div_temp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(d1_in), .o_d(d1_out)
    );

    logic [31:0] b5;
    assign b5 = d1_out.ctx.val + (d1_out.ctx.flag ? 32'd0 - d1_out.num : d1_out.num);

    // carry b5 + 8 as the temperature result
    baro_pkg::t_ctx n_c4;
    always_comb begin
        n_c4     = d1_out.ctx;
        n_c4.val = b5 + baro_pkg::TEMP_ROUND;
    end

    // pressure terms
    logic [31:0] sq, x3, t3, x3b;
    always_comb begin
        sq  = $unsigned($signed(r5_b6sq) >>> 12);
        x3  = $unsigned($signed(r6_qosq) >>> 11) + r6_x2;
        t3  = ((a1 * 32'd4 + x3) << baro_pkg::OSS) + 32'd2;
        x3b = $unsigned($signed(r6_x1b + $unsigned($signed(r6_qssq) >>> 16) + 32'd2)
                        >>> 2);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ut <= i_s_tdata[15:0];
            r1_c.op   <= i_s_tuser;
            r1_c.up   <= i_s_tdata[34:16];
            r1_c.bad  <= 1'b0;
            r1_c.flag <= 1'b0;
            r1_c.val  <= '0;
            r2_x1 <= n_x1;
            r2_c  <= r1_c;
            r4_b6 <= b5 - baro_pkg::B6_OFFSET;
            r4_c  <= n_c4;
            r5_b6sq <= r4_b6 * r4_b6;
            r5_a2b6 <= a2 * r4_b6;
            r5_a3b6 <= a3 * r4_b6;
            r5_c    <= r4_c;
            r6_qosq <= qo * sq;
            r6_qssq <= qs * sq;
            r6_x2   <= $unsigned($signed(r5_a2b6) >>> 11);
            r6_x1b  <= $unsigned($signed(r5_a3b6) >>> 13);
            r6_c    <= r5_c;
            r7_b3   <= $unsigned($signed(t3 + (t3[31] ? 32'd3 : 32'd0)) >>> 2);
            r7_x3b  <= x3b;
            r7_c    <= r6_c;
            r8_b4   <= (a4 * (r7_x3b + baro_pkg::B4_BIAS)) >> 15;
            r8_b7   <= ({13'd0, r7_c.up} - r7_b3) * baro_pkg::B7_SCALE;
            r8_c    <= r7_c;
        end
    end

    // second divider
    always_comb begin
        d2_in.valid    = r8_v;
        d2_in.rem      = '0;
        d2_in.num      = r8_b7[31] ? r8_b7 : r8_b7 << 1;
        d2_in.den      = r8_b4;
        d2_in.ctx      = r8_c;
        d2_in.ctx.flag = r8_b7[31];
        d2_in.ctx.bad  = r8_c.bad | ((r8_c.op == baro_pkg::OP_PRESS) && (r8_b4 == 32'd0));
    end

    baro_div_row u_div_press (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(d2_in), .o_d(d2_out)
    );

    // final polynomial correction
    logic [31:0] psh, pfin;
    assign psh  = $unsigned($signed(r10_p) >>> 8);
    assign pfin = r12_p + $unsigned($signed(r12_x1 + r12_x2 + baro_pkg::POLY_BIAS) >>> 4);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_p   <= d2_out.ctx.flag ? d2_out.num << 1 : d2_out.num;
            r10_c   <= d2_out.ctx;
            r11_p   <= r10_p;
            r11_sq  <= psh * psh;
            r11_lin <= baro_pkg::POLY_LIN * r10_p;
            r11_c   <= r10_c;
            r12_p   <= r11_p;
            r12_x1  <= $unsigned($signed(r11_sq * baro_pkg::POLY_SQ) >>> 16);
            r12_x2  <= $unsigned($signed(r11_lin) >>> 16);
            r12_c   <= r11_c;
            r_out_st <= r12_c.bad;
            if (r12_c.bad) begin
                r_out_val <= '0;
            end else if (r12_c.op == baro_pkg::OP_TEMP) begin
                r_out_val <= r12_c.val;
            end else begin
                r_out_val <= pfin;
            end
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_val;
    assign o_m_tuser  = r_out_st;

endmodule

// ===== hdl/baro_div_cell.sv =====
module baro_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  baro_pkg::t_div i_d,
    output baro_pkg::t_div o_d
);

    logic [32:0]    trial;
    logic           ge;
    baro_pkg::t_div n_d;
    baro_pkg::t_div r_d;

    always_comb begin
        trial = {i_d.rem, i_d.num[31]} - {1'b0, i_d.den};
        ge    = ~trial[32];
        n_d   = i_d;
        n_d.rem = ge ? trial[31:0] : {i_d.rem[30:0], i_d.num[31]};
        n_d.num = {i_d.num[30:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_d.valid <= n_d.valid;
        end
        if (i_en) begin
            r_d.rem <= n_d.rem;
            r_d.num <= n_d.num;
            r_d.den <= n_d.den;
            r_d.ctx <= n_d.ctx;
        end
    end

    assign o_d = r_d;

endmodule

// ===== hdl/baro_div_row.sv =====
module baro_div_row (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  baro_pkg::t_div i_d,
    output baro_pkg::t_div o_d
);

    baro_pkg::t_div chain [0:baro_pkg::DIV_STEPS];

    assign chain[0] = i_d;

    // one quotient bit per cell, most significant first
    for (genvar g = 0; g < baro_pkg::DIV_STEPS; g++) begin : g_cell
        baro_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_d     (chain[g]),
            .o_d     (chain[g+1])
        );
    end

    assign o_d = chain[baro_pkg::DIV_STEPS];

endmodule

// ===== hdl/baro_checker.sv =====
module baro_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic        o_m_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("output word changed while stalled");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == 32'd0)
        else $error("fault word carries a nonzero value");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == !(o_m_tvalid && !i_m_tready))
        else $error("input ready does not follow output backpressure");

endmodule

bind barometer_compensation baro_checker u_baro_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
